// ----- hw/rtl/trie_pkg.sv -----
package trie_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int ALPHABET_DEF   = 26;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_PREFIX = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] letter;
    logic       last_letter;
  } trie_in_t;

  typedef struct packed {
    logic found;
    logic pool_full;
  } trie_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } trie_state_t;

endpackage

// ----- hw/rtl/trie_ram.sv -----
module trie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/trie_insert_and_lookup.sv -----
// Prefix trie over a node memory, one letter per request. Insert, whole-word search and
// starts-with requests share one cursor that walks from the root; a result comes out only
// on the request marked as the last letter, after which the cursor returns to the root.
// Each letter passes through idle, which reads the child entry from the synchronous node
// memory, and execute, which acts on it (follow, allocate or fail, with the write-back in
// that same cycle). A last letter waits in execute while the previous result is still held
// on the output. The word-end mark of a node is kept in the child entry that points to it,
// so one read per letter answers both questions. After reset the node memory is cleared
// one entry per cycle, all NODE_COUNT*ALPHABET entries; no request is taken until then.
// Requests with an undefined operation code are taken and dropped without any effect.
module trie_insert_and_lookup #(
  parameter int NODE_COUNT = trie_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET   = trie_pkg::ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  trie_pkg::trie_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output trie_pkg::trie_out_t out_data
);

  import trie_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int DEPTH  = NODE_COUNT * ALPHABET;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int ENT_W  = NODE_W + 1;

  trie_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  trie_in_t          item_r, item_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [NODE_W:0]   next_free_r, next_free_nxt;
  logic              failed_r, failed_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  trie_out_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ENT_W-1:0]  ram_rdata;
  logic [SLOT_W-1:0] slot_in;
  logic              in_letter_ok;
  logic              item_letter_ok;
  logic              pool_empty;
  logic              alloc;

  // Entry layout: top bit marks the child node as a word end, the rest is the child index.
  trie_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_in),
    .rdata (ram_rdata)
  );

  assign slot_in = SLOT_W'(cursor_r) * SLOT_W'(ALPHABET) + SLOT_W'(in_data.letter);
  assign in_letter_ok   = {27'd0, in_data.letter} < 32'(ALPHABET);
  assign item_letter_ok = {27'd0, item_r.letter} < 32'(ALPHABET);
  assign pool_empty     = next_free_r >= (NODE_W + 1)'(NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      next_free_r <= (NODE_W + 1)'(1);
      failed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      next_free_r <= next_free_nxt;
      failed_r    <= failed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    slot_nxt      = slot_r;
    cursor_nxt    = cursor_r;
    next_free_nxt = next_free_r;
    failed_nxt    = failed_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    alloc         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == SLOT_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.func != FUNC_NONE) begin
          item_nxt  = in_data;
          slot_nxt  = slot_in;
          ram_re    = !failed_r && in_letter_ok;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (!(item_r.last_letter && out_valid_r && !out_ready)) begin
          logic              fail;
          logic              ovf;
          logic              end_mark;
          logic [NODE_W-1:0] cur;
          fail     = failed_r;
          ovf      = ovf_r;
          end_mark = 1'b0;
          cur      = cursor_r;
          if (!failed_r) begin
            if (!item_letter_ok) begin
              fail = 1'b1;
            end else if (ram_rdata[NODE_W-1:0] != '0) begin
              cur      = ram_rdata[NODE_W-1:0];
              end_mark = ram_rdata[NODE_W];
              if (item_r.func == FUNC_INSERT && item_r.last_letter) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, ram_rdata[NODE_W-1:0]};
              end
            end else if (item_r.func == FUNC_INSERT) begin
              if (pool_empty) begin
                fail = 1'b1;
                ovf  = 1'b1;
              end else begin
                alloc         = 1'b1;
                ram_we        = 1'b1;
                ram_wdata     = {item_r.last_letter, next_free_r[NODE_W-1:0]};
                cur           = next_free_r[NODE_W-1:0];
                end_mark      = item_r.last_letter;
                next_free_nxt = next_free_r + (NODE_W + 1)'(1);
              end
            end else begin
              fail = 1'b1;
            end
          end

          if (item_r.last_letter) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.pool_full = ovf;
            if (item_r.func == FUNC_SEARCH) begin
              out_data_nxt.found = !fail && end_mark;
            end else begin
              out_data_nxt.found = !fail;
            end
            cursor_nxt = '0;
            failed_nxt = 1'b0;
            ovf_nxt    = 1'b0;
          end else begin
            cursor_nxt = cur;
            failed_nxt = fail;
            ovf_nxt    = ovf;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("request taken during the clearing pass");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= (NODE_W + 1)'(NODE_COUNT))
    else $error("free node index ran past the pool");

  a_alloc_advances: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> next_free_r == $past(next_free_r) + (NODE_W + 1)'(1))
    else $error("allocation did not advance the free node index");

  a_full_means_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.pool_full |-> !out_data_r.found)
    else $error("overflowed word reported as found");
`endif

endmodule
